// ----- src/dlxie_pkg.sv -----
// ----------------------------------------------------------------------------
// dlxie_pkg
// Shared constants, opcodes and structs of the dlx instruction execute core.
// ----------------------------------------------------------------------------
package dlxie_pkg;

  localparam int XLEN          = 32;
  localparam int BYTE_W        = 8;
  localparam int REG_COUNT     = 32;
  localparam int REG_AW        = $clog2(REG_COUNT);
  // byte count of the data memory, a power of two
  localparam int MEM_BYTES     = 65536;
  localparam int MEM_AW        = $clog2(MEM_BYTES);
  localparam int MEM_LANES     = 4;
  localparam int LANE_AW       = $clog2(MEM_LANES);
  localparam int MEM_ROWS      = MEM_BYTES / MEM_LANES;
  localparam int ROW_AW        = MEM_AW - LANE_AW;
  localparam int PROGRAM_WORDS = 1024;
  localparam int INSN_SHIFT    = 2;

  localparam logic [XLEN-1:0] INSN_BYTES = 32'd4;
  localparam logic [XLEN-1:0] BYTE_MASK  = 32'h0000_00ff;

  typedef enum logic [5:0] {
    OP_LB   = 6'd0,
    OP_LW   = 6'd1,
    OP_SB   = 6'd2,
    OP_SW   = 6'd3,
    OP_ADDI = 6'd4,
    OP_SUBI = 6'd5,
    OP_ANDI = 6'd6,
    OP_ORI  = 6'd7,
    OP_XORI = 6'd8,
    OP_SGTI = 6'd9,
    OP_SEQI = 6'd10,
    OP_SGEI = 6'd11,
    OP_SLTI = 6'd12,
    OP_SNEI = 6'd13,
    OP_SLEI = 6'd14,
    OP_BEQZ = 6'd15,
    OP_BNEZ = 6'd16,
    OP_JR   = 6'd17,
    OP_ADD  = 6'd18,
    OP_SUB  = 6'd19,
    OP_AND  = 6'd20,
    OP_OR   = 6'd21,
    OP_XOR  = 6'd22,
    OP_SLLI = 6'd23,
    OP_SRLI = 6'd24,
    OP_SGT  = 6'd25,
    OP_SLT  = 6'd26,
    OP_SEQ  = 6'd27,
    OP_SNE  = 6'd28,
    OP_SGE  = 6'd29,
    OP_SLE  = 6'd30,
    OP_HALT = 6'd31,
    OP_OP   = 6'd32
  } mode_e;

  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] idx;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic              word;
    logic [MEM_AW-1:0] addr;
    logic [XLEN-1:0]   wdata;
  } dmem_req_t;

endpackage

// ----- src/dlxie_if.sv -----
// ----------------------------------------------------------------------------
// dlxie_in_if / dlxie_out_if
// Valid/ready channels carrying decoded instructions and execution results.
// ----------------------------------------------------------------------------
interface dlxie_in_if;
  logic               valid;
  logic               ready;
  logic [5:0]         mode;
  logic [4:0]         src1_index;
  logic [4:0]         src2_index;
  logic [4:0]         dest_index;
  logic signed [31:0] immediate;
  logic               target_found;
  logic [9:0]         target_index;

  modport source (
    output valid, mode, src1_index, src2_index, dest_index, immediate,
           target_found, target_index,
    input  ready
  );

  modport sink (
    input  valid, mode, src1_index, src2_index, dest_index, immediate,
           target_found, target_index,
    output ready
  );
endinterface

interface dlxie_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        print_valid;
  logic [31:0] print_value;
  logic        print_from_memory;
  logic        halted;
  logic        label_missing;

  modport source (
    output valid, next_pc, print_valid, print_value, print_from_memory, halted,
           label_missing,
    input  ready
  );

  modport sink (
    input  valid, next_pc, print_valid, print_value, print_from_memory, halted,
           label_missing,
    output ready
  );
endinterface

// ----- src/dlx_instruction_execute_core.sv -----
// ----------------------------------------------------------------------------
// dlx_instruction_execute_core
// Executes one decoded dlx integer instruction per transfer against the
// register file, the data memory, the program counter and the halt flag.
// ----------------------------------------------------------------------------
// in_i carries decoded instructions, out_o one result per instruction, both
// valid/ready. A transfer on in_i is possible in every cycle unless out_o is
// stalled; dependent instructions follow back to back through operand
// bypassing. Stages: register file read on the input transfer, execute plus
// memory access, load data and write-back, then the output register. The
// sustained rate is one instruction per cycle while out_o is not stalled.
// The stage split is set by the registered reads of the register file and
// of the data memory.
// Reset clears the program counter, the halt flag, the pipeline valids and
// the register file valid bits, so every register reads zero; the data
// memory is not cleared. When out_o is stalled with a result waiting, the
// whole pipeline holds and in_i.ready drops until that result is taken.
// ----------------------------------------------------------------------------
module dlx_instruction_execute_core
  import dlxie_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  dlxie_in_if.sink     in_i,
  dlxie_out_if.source  out_o
);

  typedef struct packed {
    logic [5:0]        mode;
    logic [REG_AW-1:0] src1;
    logic [REG_AW-1:0] rb;
    logic              alt;
    logic [REG_AW-1:0] dest;
    logic [XLEN-1:0]   imm;
    logic              found;
    logic [XLEN-1:0]   target;
  } s1_t;

  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] dest;
    logic [XLEN-1:0]   res;
    logic              ld_b;
    logic              ld_w;
    logic              pvalid;
    logic              pmem;
    logic [XLEN-1:0]   pval;
    logic [XLEN-1:0]   npc;
    logic              halted;
    logic              missing;
  } s2_t;

  typedef struct packed {
    logic [XLEN-1:0] next_pc;
    logic            print_valid;
    logic [XLEN-1:0] print_value;
    logic            print_from_memory;
    logic            halted;
    logic            label_missing;
  } out_t;

  logic              adv;
  logic              in_xfer;
  logic              in_store;
  logic [REG_AW-1:0] rb_sel;

  logic              s1_valid_q;
  s1_t               s1_q;
  s1_t               s1_d;
  logic              s2_valid_q;
  s2_t               s2_q;
  s2_t               s2_d;
  logic              out_valid_q;
  out_t              out_q;

  logic [XLEN-1:0]   pc_q;
  logic              halt_q;
  rf_wr_t            byp_q;

  logic [XLEN-1:0]   rf_a;
  logic [XLEN-1:0]   rf_b;
  rf_wr_t            rf_wr;
  logic [XLEN-1:0]   s2_wdata;
  logic [XLEN-1:0]   mem_word;
  dmem_req_t         mem_req;

  logic [XLEN-1:0]   op_a;
  logic [XLEN-1:0]   op_b;
  logic [XLEN-1:0]   addr;
  logic              take;
  logic              ex_we;
  logic              ex_rd;
  logic              ex_wr;
  logic [XLEN-1:0]   npc;
  logic              halt_d;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;
  assign in_xfer    = in_i.valid && adv;
  assign in_store   = (in_i.mode == OP_SB) || (in_i.mode == OP_SW);
  assign rb_sel     = in_store ? in_i.dest_index : in_i.src2_index;

  always_comb begin
    s1_d.mode   = in_i.mode;
    s1_d.src1   = in_i.src1_index;
    s1_d.rb     = rb_sel;
    s1_d.alt    = in_i.src2_index != '0;
    s1_d.dest   = in_i.dest_index;
    s1_d.imm    = in_i.immediate;
    s1_d.found  = in_i.target_found && (32'(in_i.target_index) < 32'(PROGRAM_WORDS));
    s1_d.target = 32'(in_i.target_index) << INSN_SHIFT;
  end

  dlxie_regfile u_regfile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (in_xfer),
    .ra_i    (in_i.src1_index),
    .rb_i    (rb_sel),
    .wr_i    (rf_wr),
    .rd_a_o  (rf_a),
    .rd_b_o  (rf_b)
  );

  // write-back data of the instruction in the last stage
  always_comb begin
    if (s2_q.ld_w) begin
      s2_wdata = mem_word;
    end else if (s2_q.ld_b) begin
      s2_wdata = mem_word & BYTE_MASK;
    end else begin
      s2_wdata = s2_q.res;
    end
  end

  always_comb begin
    rf_wr.we   = adv && s2_valid_q && s2_q.we;
    rf_wr.idx  = s2_q.dest;
    rf_wr.data = s2_wdata;
  end

  // operand bypass: last stage first, then the most recent write
  always_comb begin
    if (s1_q.src1 == '0) begin
      op_a = '0;
    end else if (s2_valid_q && s2_q.we && (s2_q.dest == s1_q.src1)) begin
      op_a = s2_wdata;
    end else if (byp_q.we && (byp_q.idx == s1_q.src1)) begin
      op_a = byp_q.data;
    end else begin
      op_a = rf_a;
    end
    if (s1_q.rb == '0) begin
      op_b = '0;
    end else if (s2_valid_q && s2_q.we && (s2_q.dest == s1_q.rb)) begin
      op_b = s2_wdata;
    end else if (byp_q.we && (byp_q.idx == s1_q.rb)) begin
      op_b = byp_q.data;
    end else begin
      op_b = rf_b;
    end
  end

  assign addr = op_a + s1_q.imm;
  assign take = (s1_q.mode == OP_BEQZ) ? (op_a == '0) : (op_a != '0);

  always_comb begin
    s2_d         = '0;
    s2_d.dest    = s1_q.dest;
    ex_we        = 1'b0;
    ex_rd        = 1'b0;
    ex_wr        = 1'b0;
    npc          = pc_q + INSN_BYTES;
    halt_d       = halt_q;
    if (halt_q) begin
      npc = pc_q;
    end else begin
      case (s1_q.mode)
        OP_LB: begin
          ex_we     = 1'b1;
          ex_rd     = 1'b1;
          s2_d.ld_b = 1'b1;
        end
        OP_LW: begin
          ex_we     = 1'b1;
          ex_rd     = 1'b1;
          s2_d.ld_w = 1'b1;
        end
        OP_SB, OP_SW: ex_wr = 1'b1;
        OP_ADDI: begin ex_we = 1'b1; s2_d.res = op_a + s1_q.imm; end
        OP_SUBI: begin ex_we = 1'b1; s2_d.res = op_a - s1_q.imm; end
        OP_ANDI: begin ex_we = 1'b1; s2_d.res = op_a & s1_q.imm; end
        OP_ORI:  begin ex_we = 1'b1; s2_d.res = op_a | s1_q.imm; end
        OP_XORI: begin ex_we = 1'b1; s2_d.res = op_a ^ s1_q.imm; end
        OP_SGTI: begin
          ex_we    = 1'b1;
          s2_d.res = XLEN'($signed(s1_q.imm) < $signed(op_a));
        end
        OP_SEQI: begin ex_we = 1'b1; s2_d.res = XLEN'(op_a == s1_q.imm); end
        OP_SGEI: begin
          ex_we    = 1'b1;
          s2_d.res = XLEN'(!($signed(op_a) < $signed(s1_q.imm)));
        end
        OP_SLTI: begin
          ex_we    = 1'b1;
          s2_d.res = XLEN'($signed(op_a) < $signed(s1_q.imm));
        end
        OP_SNEI: begin ex_we = 1'b1; s2_d.res = XLEN'(op_a != s1_q.imm); end
        OP_SLEI: begin
          ex_we    = 1'b1;
          s2_d.res = XLEN'(!($signed(s1_q.imm) < $signed(op_a)));
        end
        OP_BEQZ, OP_BNEZ: begin
          if (!s1_q.alt) begin
            if (take) begin
              npc = pc_q + INSN_BYTES + s1_q.imm;
            end
          end else if (!s1_q.found) begin
            s2_d.missing = 1'b1;
            npc          = pc_q;
          end else if (take) begin
            npc = s1_q.target;
          end
        end
        OP_JR: begin
          if (!s1_q.alt) begin
            npc = op_a;
          end else if (!s1_q.found) begin
            s2_d.missing = 1'b1;
            npc          = pc_q;
          end else begin
            npc = s1_q.target;
          end
        end
        OP_ADD:  begin ex_we = 1'b1; s2_d.res = op_a + op_b; end
        OP_SUB:  begin ex_we = 1'b1; s2_d.res = op_a - op_b; end
        OP_AND:  begin ex_we = 1'b1; s2_d.res = op_a & op_b; end
        OP_OR:   begin ex_we = 1'b1; s2_d.res = op_a | op_b; end
        OP_XOR:  begin ex_we = 1'b1; s2_d.res = op_a ^ op_b; end
        OP_SLLI: begin ex_we = 1'b1; s2_d.res = op_a << s1_q.imm[4:0]; end
        OP_SRLI: begin ex_we = 1'b1; s2_d.res = op_a >> s1_q.imm[4:0]; end
        OP_SGT:  begin ex_we = 1'b1; s2_d.res = XLEN'(op_a > op_b); end
        OP_SLT:  begin ex_we = 1'b1; s2_d.res = XLEN'(op_a < op_b); end
        OP_SEQ:  begin ex_we = 1'b1; s2_d.res = XLEN'(op_a == op_b); end
        OP_SNE:  begin ex_we = 1'b1; s2_d.res = XLEN'(op_a != op_b); end
        OP_SGE:  begin ex_we = 1'b1; s2_d.res = XLEN'(op_a >= op_b); end
        OP_SLE:  begin ex_we = 1'b1; s2_d.res = XLEN'(op_a <= op_b); end
        OP_HALT: begin
          halt_d = 1'b1;
          npc    = pc_q;
        end
        OP_OP: begin
          s2_d.pvalid = 1'b1;
          if (s1_q.alt) begin
            s2_d.pmem = 1'b1;
            ex_rd     = 1'b1;
          end else begin
            s2_d.pval = op_a;
          end
        end
        default: ;
      endcase
    end
    s2_d.we     = ex_we && (s1_q.dest != '0);
    s2_d.npc    = npc;
    s2_d.halted = halt_d;
  end

  always_comb begin
    mem_req.rd    = adv && s1_valid_q && ex_rd;
    mem_req.wr    = adv && s1_valid_q && ex_wr;
    mem_req.word  = s1_q.mode == OP_SW;
    mem_req.addr  = addr[MEM_AW-1:0];
    mem_req.wdata = op_b;
  end

  dlxie_dmem u_dmem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      halt_q      <= 1'b0;
      byp_q       <= '0;
    end else if (adv) begin
      s1_valid_q  <= in_i.valid;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
      if (s1_valid_q) begin
        pc_q   <= npc;
        halt_q <= halt_d;
      end
      if (rf_wr.we) begin
        byp_q <= rf_wr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (in_xfer) begin
        s1_q <= s1_d;
      end
      s2_q                    <= s2_d;
      out_q.next_pc           <= s2_q.npc;
      out_q.print_valid       <= s2_q.pvalid;
      out_q.print_value       <= s2_q.pmem ? (mem_word & BYTE_MASK) : s2_q.pval;
      out_q.print_from_memory <= s2_q.pmem;
      out_q.halted            <= s2_q.halted;
      out_q.label_missing     <= s2_q.missing;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.next_pc           = out_q.next_pc;
  assign out_o.print_valid       = out_q.print_valid;
  assign out_o.print_value       = out_q.print_value;
  assign out_o.print_from_memory = out_q.print_from_memory;
  assign out_o.halted            = out_q.halted;
  assign out_o.label_missing     = out_q.label_missing;

`ifndef SYNTHESIS
  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared while running");

  a_pc_frozen_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> $stable(pc_q))
    else $error("program counter moved while halted");

  a_no_r0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_wr.we |-> (rf_wr.idx != '0))
    else $error("write-back to register zero");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty output register");
`endif

endmodule

// ----- src/dlxie_regfile.sv -----
// ----------------------------------------------------------------------------
// dlxie_regfile
// Register file with two registered read ports, one write port and per-entry
// valid bits so that unwritten registers read as zero after reset.
// ----------------------------------------------------------------------------
module dlxie_regfile
  import dlxie_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [REG_AW-1:0] ra_i,
  input  logic [REG_AW-1:0] rb_i,
  input  rf_wr_t            wr_i,
  output logic [XLEN-1:0]   rd_a_o,
  output logic [XLEN-1:0]   rd_b_o
);

  logic [XLEN-1:0]      rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid_q;
  logic [XLEN-1:0]      rd_a_q;
  logic [XLEN-1:0]      rd_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.we) begin
      valid_q[wr_i.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      rf_mem[wr_i.idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_a_q <= valid_q[ra_i] ? rf_mem[ra_i] : '0;
      rd_b_q <= valid_q[rb_i] ? rf_mem[rb_i] : '0;
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

// ----- src/dlxie_dmem.sv -----
// ----------------------------------------------------------------------------
// dlxie_dmem
// Byte-addressed data memory in four byte lanes, so that a word at any byte
// address, wrapping at the top, is read or written in a single access.
// ----------------------------------------------------------------------------
module dlxie_dmem
  import dlxie_pkg::*;
(
  input  logic            clk_i,
  input  dmem_req_t       req_i,
  output logic [XLEN-1:0] rdata_o
);

  logic [BYTE_W-1:0]    lane_mem [MEM_LANES][MEM_ROWS];
  logic [ROW_AW-1:0]    row [MEM_LANES];
  logic [BYTE_W-1:0]    wbyte [MEM_LANES];
  logic [MEM_LANES-1:0] lane_we;
  logic [BYTE_W-1:0]    rd_q [MEM_LANES];
  logic [LANE_AW-1:0]   lo_q;

  // lane j holds byte k of the word, k = (j - addr) mod lanes
  always_comb begin
    logic [LANE_AW-1:0] k;
    logic [MEM_AW-1:0]  lane_addr;
    k         = '0;
    lane_addr = '0;
    for (int j = 0; j < MEM_LANES; j++) begin
      k          = LANE_AW'(j) - req_i.addr[LANE_AW-1:0];
      lane_addr  = req_i.addr + MEM_AW'(k);
      row[j]     = lane_addr[MEM_AW-1:LANE_AW];
      wbyte[j]   = BYTE_W'(req_i.wdata >> {k, 3'b000});
      lane_we[j] = req_i.wr && (req_i.word || (k == '0));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MEM_LANES; j++) begin
      if (lane_we[j]) begin
        lane_mem[j][row[j]] <= wbyte[j];
      end
      if (req_i.rd) begin
        rd_q[j] <= lane_mem[j][row[j]];
      end
    end
    if (req_i.rd) begin
      lo_q <= req_i.addr[LANE_AW-1:0];
    end
  end

  always_comb begin
    logic [LANE_AW-1:0] lane;
    lane = '0;
    for (int k = 0; k < MEM_LANES; k++) begin
      lane = lo_q + LANE_AW'(k);
      rdata_o[BYTE_W*k +: BYTE_W] = rd_q[lane];
    end
  end

endmodule

// ----- tb/dlx_instruction_execute_core_tb.sv -----
// ----------------------------------------------------------------------------
// dlx_instruction_execute_core_tb
// Self-checking bench for the dlx instruction execute core. An instruction
// stream is built at time zero against an architectural copy of the register
// file, data memory, pc and halt flag, and each instruction carries its
// expected result. The driver and the receiver idle at random; results are
// compared field by field in order of transfer.
// ----------------------------------------------------------------------------
module dlx_instruction_execute_core_tb;
  import dlxie_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned RANDOM_INSNS = 920;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        print_valid;
    logic [31:0] print_value;
    logic        print_from_memory;
    logic        halted;
    logic        label_missing;
  } outcome_t;

  typedef struct packed {
    logic [5:0]  mode;
    logic [4:0]  src1;
    logic [4:0]  src2;
    logic [4:0]  dest;
    logic [31:0] imm;
    logic        found;
    logic [9:0]  target;
    outcome_t    want;
  } insn_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dlxie_in_if  in_if ();
  dlxie_out_if out_if ();

  dlx_instruction_execute_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // architectural state
  logic [31:0]       arch_regs [REG_COUNT];
  logic [7:0]        arch_mem  [MEM_BYTES];
  bit                mem_written [MEM_BYTES];
  logic [31:0]       arch_pc;
  logic              arch_halted;
  logic [MEM_AW-1:0] byte_addrs [$];
  logic [MEM_AW-1:0] word_addrs [$];

  insn_t       insn_q [$];
  outcome_t    outcome_q [$];
  insn_t       cur_insn;
  outcome_t    oldest;
  int unsigned total, sent_cnt, n_checked, errors;
  int unsigned n_mem, n_flow, n_print;
  int unsigned send_idle, stall_left, hold_left, quiet;
  bit          hold_done;

  function automatic logic [31:0] reg_rd(logic [4:0] idx);
    return (idx == '0) ? '0 : arch_regs[idx];
  endfunction

  function automatic logic [7:0] mem_rd(logic [31:0] addr);
    return arch_mem[addr[MEM_AW-1:0]];
  endfunction

  function automatic void mem_wr(logic [31:0] addr, logic [7:0] data);
    arch_mem[addr[MEM_AW-1:0]] = data;
    if (!mem_written[addr[MEM_AW-1:0]]) begin
      mem_written[addr[MEM_AW-1:0]] = 1'b1;
      byte_addrs.push_back(addr[MEM_AW-1:0]);
    end
  endfunction

  function automatic outcome_t execute_insn(insn_t ins);
    outcome_t    res;
    logic [31:0] a, b, addr, npc, wval, target;
    logic        alt, hit, wen, take;
    a = reg_rd(ins.src1);
    b = reg_rd(ins.src2);
    addr = a + ins.imm;
    alt = (ins.src2 != '0);
    hit = ins.found && (int'(ins.target) < PROGRAM_WORDS);
    target = 32'(ins.target) << INSN_SHIFT;
    npc = arch_pc + INSN_BYTES;
    res = '0;
    wen = 1'b1;
    wval = '0;
    if (arch_halted) begin
      npc = arch_pc;
      wen = 1'b0;
    end else begin
      case (ins.mode)
        OP_LB: wval = {24'd0, mem_rd(addr)};
        OP_LW: wval = {mem_rd(addr + 3), mem_rd(addr + 2), mem_rd(addr + 1), mem_rd(addr)};
        OP_SB: begin
          wen = 1'b0;
          mem_wr(addr, 8'(reg_rd(ins.dest) & BYTE_MASK));
        end
        OP_SW: begin
          wen = 1'b0;
          word_addrs.push_back(addr[MEM_AW-1:0]);
          for (int k = 0; k < MEM_LANES; k++) mem_wr(addr + k, 8'(reg_rd(ins.dest) >> (8 * k)));
        end
        OP_ADDI: wval = a + ins.imm;
        OP_SUBI: wval = a - ins.imm;
        OP_ANDI: wval = a & ins.imm;
        OP_ORI:  wval = a | ins.imm;
        OP_XORI: wval = a ^ ins.imm;
        OP_SGTI: wval = 32'($signed(ins.imm) < $signed(a));
        OP_SEQI: wval = 32'(a == ins.imm);
        OP_SGEI: wval = 32'(!($signed(a) < $signed(ins.imm)));
        OP_SLTI: wval = 32'($signed(a) < $signed(ins.imm));
        OP_SNEI: wval = 32'(a != ins.imm);
        OP_SLEI: wval = 32'(!($signed(ins.imm) < $signed(a)));
        OP_BEQZ, OP_BNEZ: begin
          wen = 1'b0;
          take = (ins.mode == OP_BEQZ) ? (a == '0) : (a != '0);
          if (!alt) begin
            if (take) npc = arch_pc + INSN_BYTES + ins.imm;
          end else if (!hit) begin
            res.label_missing = 1'b1;
            npc = arch_pc;
          end else if (take) begin
            npc = target;
          end
        end
        OP_JR: begin
          wen = 1'b0;
          if (!alt) begin
            npc = a;
          end else if (!hit) begin
            res.label_missing = 1'b1;
            npc = arch_pc;
          end else begin
            npc = target;
          end
        end
        OP_ADD:  wval = a + b;
        OP_SUB:  wval = a - b;
        OP_AND:  wval = a & b;
        OP_OR:   wval = a | b;
        OP_XOR:  wval = a ^ b;
        OP_SLLI: wval = a << ins.imm[4:0];
        OP_SRLI: wval = a >> ins.imm[4:0];
        OP_SGT:  wval = 32'(a > b);
        OP_SLT:  wval = 32'(a < b);
        OP_SEQ:  wval = 32'(a == b);
        OP_SNE:  wval = 32'(a != b);
        OP_SGE:  wval = 32'(a >= b);
        OP_SLE:  wval = 32'(a <= b);
        OP_HALT: begin
          wen = 1'b0;
          arch_halted = 1'b1;
          npc = arch_pc;
        end
        OP_OP: begin
          wen = 1'b0;
          res.print_valid = 1'b1;
          res.print_from_memory = alt;
          res.print_value = alt ? {24'd0, mem_rd(addr)} : a;
        end
        default: wen = 1'b0;
      endcase
      if (wen && ins.dest != '0) arch_regs[ins.dest] = wval;
      arch_pc = npc;
    end
    res.next_pc = npc;
    res.halted = arch_halted;
    return res;
  endfunction

  task automatic push_insn(logic [5:0] mode, logic [4:0] s1, logic [4:0] s2, logic [4:0] d,
                           logic [31:0] imm, logic found = 1'b1, logic [9:0] tgt = '0);
    insn_t ins;
    ins.mode = mode;
    ins.src1 = s1;
    ins.src2 = s2;
    ins.dest = d;
    ins.imm = imm;
    ins.found = found;
    ins.target = tgt;
    if (mode <= OP_SW || (mode == OP_OP && s2 != '0)) n_mem++;
    if (mode >= OP_BEQZ && mode <= OP_JR) n_flow++;
    if (mode == OP_OP) n_print++;
    ins.want = execute_insn(ins);
    insn_q.push_back(ins);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      4: return 32'hffff_ffff;
      5: return 32'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [MEM_AW-1:0] pick_store_addr();
    case ($urandom_range(0, 3))
      0: return MEM_AW'($urandom_range(MEM_BYTES - 4, MEM_BYTES - 1));
      1, 2: return MEM_AW'($urandom_range(0, 255));
      default: return MEM_AW'($urandom());
    endcase
  endfunction

  // immediate that lands base + imm on the given byte, upper bits random
  function automatic logic [31:0] offset_to(logic [4:0] base, logic [MEM_AW-1:0] where);
    logic [31:0] off, a;
    a = reg_rd(base);
    off = $urandom();
    off[MEM_AW-1:0] = where - a[MEM_AW-1:0];
    return off;
  endfunction

  task automatic random_insn();
    int unsigned       pick, sel;
    logic [4:0]        s1, s2, d;
    logic [5:0]        m;
    logic [31:0]       imm;
    logic [MEM_AW-1:0] where;
    pick = $urandom_range(0, 99);
    s1 = 5'($urandom());
    s2 = 5'($urandom());
    d = 5'($urandom());
    imm = $urandom();
    if (pick < 12 || (pick < 24 && byte_addrs.size() == 0)) begin
      m = ($urandom_range(0, 1) != 0) ? OP_SW : OP_SB;
      push_insn(m, s1, s2, d, offset_to(s1, pick_store_addr()), 1'($urandom()),
                10'($urandom()));
    end else if (pick < 24) begin
      sel = $urandom_range(0, 2);
      m = (sel == 0) ? OP_LB : (sel == 1) ? OP_LW : OP_OP;
      if (m == OP_LW && word_addrs.size() == 0) m = OP_LB;
      if (m == OP_OP) s2 = 5'($urandom_range(1, 31));
      where = (m == OP_LW) ? word_addrs[$urandom_range(0, word_addrs.size() - 1)]
                           : byte_addrs[$urandom_range(0, byte_addrs.size() - 1)];
      push_insn(m, s1, s2, d, offset_to(s1, where), 1'($urandom()), 10'($urandom()));
    end else if (pick < 34) begin
      m = 6'($urandom_range(OP_ADDI, OP_SLEI));
      if ($urandom_range(0, 7) == 0) s1 = '0;
      imm = ($urandom_range(0, 3) == 0) ? reg_rd(s1) : pick_word();
      push_insn(m, s1, s2, d, imm, 1'($urandom()), 10'($urandom()));
    end else if (pick < 42) begin
      m = ($urandom_range(0, 1) != 0) ? OP_SLLI : OP_SRLI;
      push_insn(m, s1, s2, d, imm, 1'($urandom()), 10'($urandom()));
    end else if (pick < 68) begin
      sel = $urandom_range(0, 10);
      m = (sel < 5) ? 6'(OP_ADD + sel) : 6'(OP_SGT + sel - 5);
      if ($urandom_range(0, 4) == 0) s2 = s1;
      push_insn(m, s1, s2, d, imm, 1'($urandom()), 10'($urandom()));
    end else if (pick < 80) begin
      m = 6'($urandom_range(OP_BEQZ, OP_JR));
      s2 = ($urandom_range(0, 1) != 0) ? 5'd0 : 5'($urandom_range(1, 31));
      if ($urandom_range(0, 3) == 0) s1 = '0;
      push_insn(m, s1, s2, d, imm, 1'($urandom_range(0, 4) != 0), 10'($urandom()));
    end else if (pick < 92) begin
      push_insn(OP_OP, s1, 5'd0, d, imm, 1'($urandom()), 10'($urandom()));
    end else begin
      m = 6'($urandom_range(OP_OP + 1, 63));
      push_insn(m, s1, s2, d, imm, 1'($urandom()), 10'($urandom()));
    end
  endtask

  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 20)
      $display("[%0t] mismatch on %s at result %0d: got %h, want %h",
               $time, what, n_checked, got, want);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      send_idle = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        outcome_q.push_back(cur_insn.want);
        sent_cnt++;
        send_idle = (sent_cnt >= 400 && sent_cnt < 520) ? 0 : pick_idle();
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_idle > 0) begin
          send_idle--;
          in_if.valid <= 1'b0;
        end else if (insn_q.size() > 0) begin
          cur_insn = insn_q.pop_front();
          in_if.valid        <= 1'b1;
          in_if.mode         <= cur_insn.mode;
          in_if.src1_index   <= cur_insn.src1;
          in_if.src2_index   <= cur_insn.src2;
          in_if.dest_index   <= cur_insn.dest;
          in_if.immediate    <= cur_insn.imm;
          in_if.target_found <= cur_insn.found;
          in_if.target_index <= cur_insn.target;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with nothing pending", out_if.next_pc, '0);
        end else begin
          oldest = outcome_q.pop_front();
          if (out_if.next_pc !== oldest.next_pc)
            report_mismatch("next_pc", out_if.next_pc, oldest.next_pc);
          if (out_if.print_valid !== oldest.print_valid)
            report_mismatch("print_valid", 32'(out_if.print_valid), 32'(oldest.print_valid));
          if (out_if.print_value !== oldest.print_value)
            report_mismatch("print_value", out_if.print_value, oldest.print_value);
          if (out_if.print_from_memory !== oldest.print_from_memory)
            report_mismatch("print_from_memory", 32'(out_if.print_from_memory),
                            32'(oldest.print_from_memory));
          if (out_if.halted !== oldest.halted)
            report_mismatch("halted", 32'(out_if.halted), 32'(oldest.halted));
          if (out_if.label_missing !== oldest.label_missing)
            report_mismatch("label_missing", 32'(out_if.label_missing),
                            32'(oldest.label_missing));
        end
        n_checked++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!hold_done && n_checked >= 300) begin
        // long back-pressure so the pipeline fills and stalls its input
        hold_done = 1'b1;
        hold_left = 120;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (n_checked >= 600 && n_checked < 720) begin
        out_if.ready <= 1'b1;
      end else begin
        stall_left = ($urandom_range(0, 3) == 0) ? pick_idle() : 0;
        out_if.ready <= (stall_left == 0);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results pending",
               quiet, outcome_q.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.mode = '0;
    in_if.src1_index = '0;
    in_if.src2_index = '0;
    in_if.dest_index = '0;
    in_if.immediate = '0;
    in_if.target_found = 1'b0;
    in_if.target_index = '0;
    out_if.ready = 1'b0;
    for (int i = 0; i < REG_COUNT; i++) arch_regs[i] = '0;
    arch_pc = '0;
    arch_halted = 1'b0;

    // directed: extremes, wrap, r0, shift mask, compare signedness, branches
    push_insn(OP_ADDI, 5'd0, 5'd0, 5'd1, 32'h7fff_ffff);
    push_insn(OP_ADDI, 5'd0, 5'd0, 5'd2, 32'h8000_0000);
    push_insn(OP_SUBI, 5'd0, 5'd0, 5'd3, 32'h0000_0001);
    push_insn(OP_XORI, 5'd3, 5'd0, 5'd4, 32'h5a5a_00ff);
    push_insn(OP_SW, 5'd0, 5'd0, 5'd4, 32'hffff_fffe);
    push_insn(OP_LW, 5'd0, 5'd0, 5'd5, 32'h1234_fffe);
    push_insn(OP_LB, 5'd0, 5'd0, 5'd6, 32'h0000_0001);
    push_insn(OP_SB, 5'd0, 5'd0, 5'd3, 32'h0000_0040);
    push_insn(OP_OP, 5'd0, 5'd31, 5'd0, 32'h0000_0040);
    push_insn(OP_OP, 5'd2, 5'd0, 5'd0, 32'h0000_0000);
    push_insn(OP_ADDI, 5'd1, 5'd0, 5'd0, 32'h0000_0005);
    push_insn(OP_OP, 5'd0, 5'd0, 5'd31, 32'hffff_ffff);
    push_insn(OP_SLLI, 5'd3, 5'd0, 5'd7, 32'h0000_003f);
    push_insn(OP_SRLI, 5'd3, 5'd0, 5'd8, 32'h0000_0021);
    push_insn(OP_SGTI, 5'd1, 5'd0, 5'd9, 32'hffff_ffff);
    push_insn(OP_SLTI, 5'd2, 5'd0, 5'd10, 32'h0000_0000);
    push_insn(OP_SGEI, 5'd1, 5'd0, 5'd11, 32'h7fff_ffff);
    push_insn(OP_SGT, 5'd2, 5'd1, 5'd12, 32'h0000_0000);
    push_insn(OP_ADD, 5'd1, 5'd1, 5'd13, 32'h0000_0000);
    push_insn(OP_BEQZ, 5'd0, 5'd0, 5'd0, 32'hffff_fff8);
    push_insn(OP_BNEZ, 5'd0, 5'd1, 5'd0, 32'h0000_0000, 1'b1, 10'd1023);
    push_insn(OP_BEQZ, 5'd0, 5'd1, 5'd0, 32'h0000_0000, 1'b1, 10'd1023);
    push_insn(OP_BNEZ, 5'd3, 5'd31, 5'd0, 32'h0000_0000, 1'b0, 10'd5);
    push_insn(OP_JR, 5'd3, 5'd0, 5'd0, 32'h0000_0000);
    push_insn(OP_JR, 5'd0, 5'd2, 5'd0, 32'h0000_0000, 1'b0, 10'd1023);
    push_insn(OP_JR, 5'd0, 5'd2, 5'd0, 32'h0000_0000, 1'b1, 10'd0);
    push_insn(6'd63, 5'd31, 5'd31, 5'd31, 32'hffff_ffff, 1'b1, 10'd1023);

    repeat (RANDOM_INSNS) random_insn();

    // halt, then instructions that must be ignored
    push_insn(OP_HALT, 5'($urandom()), 5'($urandom()), 5'($urandom()), $urandom());
    push_insn(OP_SW, 5'd0, 5'd0, 5'd3, 32'h0000_0040);
    push_insn(OP_OP, 5'd1, 5'd0, 5'd0, 32'h0000_0000);
    total = insn_q.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent_cnt < total || outcome_q.size() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d instructions: %0d memory accesses, %0d branches and jumps, %0d reports",
             total, n_mem, n_flow, n_print);
    $display("%0d results checked, %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
